>>> hw/rtl/fra_pkg.sv
// shared types and constants of the fec ratio adaptation block
// used by fra_feature, fra_decide and fec_ratio_adaptation; depends on nothing

package fra_pkg;

  localparam int TIME_BITS_DEF = 40;
  localparam int GEN_BITS_DEF  = 32;

  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // fec_mode codes
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_FIXED = 2'd1;
  localparam logic [1:0] MODE_ADAPT = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_INIT_RATIO = 3'd0;
  localparam logic [2:0] CFG_CADENCE    = 3'd1;
  localparam logic [2:0] CFG_CONG_HOLD  = 3'd2;
  localparam logic [2:0] CFG_MIN_SAMP   = 3'd3;
  localparam logic [2:0] CFG_DOWN_HOLD  = 3'd4;

  localparam logic [2:0] RATIO_MAX = 3'd5;

  typedef enum logic [2:0] {
    RSN_OFF       = 3'd0,
    RSN_FIXED     = 3'd1,
    RSN_STARTUP   = 3'd2,
    RSN_HEALTHY   = 3'd3,
    RSN_LOSS      = 3'd4,
    RSN_CONGESTED = 3'd5,
    RSN_STALE     = 3'd6,
    RSN_INSUFF    = 3'd7
  } reason_t;

  typedef struct packed {
    logic [2:0]  init_ratio;
    logic [15:0] cadence;
    logic [15:0] cong_hold;
    logic [15:0] min_samples;
    logic [15:0] down_hold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  fec_mode;
    logic [39:0] now_ms;
    logic        congested_flag;
    logic [15:0] queue_delay;
    logic [29:0] link_rate;
    logic [15:0] rtt_ms;
    logic [40:0] feedback_time_ms;
    logic [15:0] sample_count;
    logic [15:0] lost_count;
    logic [15:0] longest_loss_run;
    logic [31:0] feedback_gen;
  } in_item_t;

  // per-snapshot values that need no state
  typedef struct packed {
    logic [1:0]  mode;
    logic        urgent;
    logic        q_ge40;
    logic [15:0] queue;
    logic [29:0] bps;
    logic [32:0] bps5p5;   // 5*bps+5, for the falling-bitrate test
    logic        fresh;
    logic        insuff;
    logic [2:0]  band;
  } feat_t;

endpackage

>>> hw/rtl/fra_feature.sv
// input register stage: loss bands, freshness, urgency and congestion end time
// depends on fra_pkg

module fra_feature #(
  parameter int TIME_BITS = fra_pkg::TIME_BITS_DEF,
  parameter int GEN_BITS  = fra_pkg::GEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fra_pkg::in_item_t    item,
  input  fra_pkg::cfg_t        cfg,
  output logic                 feat_valid,
  input  logic                 feat_ready,
  output fra_pkg::feat_t       feat,
  output logic [TIME_BITS-1:0] feat_now,
  output logic [TIME_BITS-1:0] feat_cend,
  output logic [GEN_BITS-1:0]  feat_gen
);
  import fra_pkg::*;

  localparam int FW = ((TIME_BITS > 40) ? TIME_BITS : 40) + 1;

  logic                 v_r;
  feat_t                feat_r, feat_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [TIME_BITS-1:0] cend_r, cend_nxt;
  logic [GEN_BITS-1:0]  gen_r;

  logic [FW-1:0]        now_x, fb_x, fb_age;
  logic [10:0]          rtt_c;
  logic [12:0]          stale3, stale;
  logic [25:0]          lost_k, s5, s15, s30, s50, s80;
  logic                 lt5, lt15, lt30, lt50, lt80, lossy;
  logic [2:0]           band;
  logic [TIME_BITS:0]   cend_sum;

  assign in_ready = !v_r || feat_ready;
  wire take = in_valid && in_ready;

  always_comb begin
    now_nxt = TIME_BITS'(item.now_ms);

    // feedback age against the 3*rtt window, floor 2 s
    rtt_c  = (item.rtt_ms > 16'd2000) ? 11'd2000 : item.rtt_ms[10:0];
    stale3 = 13'(rtt_c) * 13'd3;
    stale  = (stale3 < 13'd2000) ? 13'd2000 : stale3;
    now_x  = FW'(now_nxt);
    fb_x   = FW'(item.feedback_time_ms[39:0]);
    fb_age = now_x - fb_x;

    // loss bands: lost*1000 against samples*{5,15,30,50,80}
    lost_k = 26'(item.lost_count) * 26'd1000;
    s5     = 26'(item.sample_count) * 26'd5;
    s15    = 26'(item.sample_count) * 26'd15;
    s30    = 26'(item.sample_count) * 26'd30;
    s50    = 26'(item.sample_count) * 26'd50;
    s80    = 26'(item.sample_count) * 26'd80;
    lt5    = lost_k < s5;
    lt15   = lost_k < s15;
    lt30   = lost_k < s30;
    lt50   = lost_k < s50;
    lt80   = lost_k < s80;
    lossy  = (item.sample_count != 16'd0) && !lt5;
    priority if (item.sample_count == 16'd0) band = 3'd0;
    else if (lt5)  band = 3'd0;
    else if (lt15) band = 3'd1;
    else if (lt30) band = 3'd2;
    else if (lt50) band = 3'd3;
    else if (lt80) band = 3'd4;
    else           band = RATIO_MAX;
    // long rtt or bursty loss pushes one band up
    if (lossy && (item.rtt_ms >= 16'd100 || item.longest_loss_run >= 16'd3) &&
        band != RATIO_MAX) begin
      band = band + 3'd1;
    end

    // end of congestion if this snapshot triggers it, saturating
    cend_sum = (TIME_BITS+1)'(now_nxt) + (TIME_BITS+1)'(cfg.cong_hold);
    cend_nxt = cend_sum[TIME_BITS] ? '1 : cend_sum[TIME_BITS-1:0];

    feat_nxt.mode   = item.fec_mode;
    feat_nxt.urgent = item.congested_flag || (item.queue_delay >= 16'd100) ||
                      (item.link_rate == 30'd0);
    feat_nxt.q_ge40 = item.queue_delay >= 16'd40;
    feat_nxt.queue  = item.queue_delay;
    feat_nxt.bps    = item.link_rate;
    feat_nxt.bps5p5 = 33'(item.link_rate) * 33'd5 + 33'd5;
    feat_nxt.fresh  = !item.feedback_time_ms[40] && (now_x >= fb_x) &&
                      (fb_age <= FW'(stale));
    feat_nxt.insuff = item.sample_count < cfg.min_samples;
    feat_nxt.band   = band;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      feat_r <= feat_nxt;
      now_r  <= now_nxt;
      cend_r <= cend_nxt;
      gen_r  <= GEN_BITS'(item.feedback_gen);
    end
  end

  assign feat_valid = v_r;
  assign feat       = feat_r;
  assign feat_now   = now_r;
  assign feat_cend  = cend_r;
  assign feat_gen   = gen_r;

endmodule

>>> hw/rtl/fra_decide.sv
// decision stage: controller state, cadence gate, candidate confirmation, version
// depends on fra_pkg; the state registers double as the result register

module fra_decide #(
  parameter int TIME_BITS = fra_pkg::TIME_BITS_DEF,
  parameter int GEN_BITS  = fra_pkg::GEN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 feat_valid,
  output logic                 feat_ready,
  input  fra_pkg::feat_t       feat,
  input  logic [TIME_BITS-1:0] feat_now,
  input  logic [TIME_BITS-1:0] feat_cend,
  input  logic [GEN_BITS-1:0]  feat_gen,
  input  fra_pkg::cfg_t        cfg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [31:0]          res_version,
  output logic [2:0]           res_ratio,
  output logic                 res_kfp,
  output fra_pkg::reason_t     res_reason
);
  import fra_pkg::*;

  logic                 out_v_r;
  logic [1:0]           mode_r, mode_nxt;
  logic                 seen_r, seen_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [29:0]          pbps_r, pbps_nxt;
  logic [15:0]          pq_r, pq_nxt;
  logic [TIME_BITS-1:0] cend_r, cend_nxt;
  logic [2:0]           appl_r, appl_nxt;
  logic                 cv_r, cv_nxt;
  logic [2:0]           cr_r, cr_nxt;
  logic [TIME_BITS-1:0] cs_r, cs_nxt;
  logic [1:0]           cc_r, cc_nxt;
  logic [GEN_BITS-1:0]  sgen_r, sgen_nxt;
  logic [31:0]          ver_r, ver_nxt;
  logic [2:0]           hratio_r, hratio_nxt;
  logic                 hkfp_r, hkfp_nxt;
  reason_t              hrsn_r, hrsn_nxt;

  logic                 clr, gate, falling, growing, in_cong, immediate, new_cand;
  logic                 e_seen, e_cv;
  logic [TIME_BITS-1:0] e_last, e_cend, e_cs, cend_use, cs1;
  logic [29:0]          e_pbps;
  logic [15:0]          e_pq;
  logic [2:0]           e_appl, e_cr, init_sat, desired;
  logic [1:0]           e_cc, cc1;
  logic [GEN_BITS-1:0]  e_sgen;
  reason_t              reason;

  assign feat_ready = !out_v_r || res_ready;
  wire take = feat_valid && feat_ready;

  always_comb begin
    init_sat = (cfg.init_ratio > RATIO_MAX) ? RATIO_MAX : cfg.init_ratio;

    // mode change or time going back: back to reset values, but the applied ratio goes to init_ratio; version kept
    clr    = (feat.mode != mode_r) || (seen_r && (feat_now < last_r));
    e_seen = clr ? 1'b0 : seen_r;
    e_last = clr ? '0 : last_r;
    e_pbps = clr ? '0 : pbps_r;
    e_pq   = clr ? '0 : pq_r;
    e_cend = clr ? '0 : cend_r;
    e_appl = clr ? init_sat : appl_r;
    e_cv   = clr ? 1'b0 : cv_r;
    e_cr   = clr ? '0 : cr_r;
    e_cs   = clr ? '0 : cs_r;
    e_cc   = clr ? '0 : cc_r;
    e_sgen = clr ? '0 : sgen_r;

    gate = !feat.urgent && e_seen &&
           (TIME_BITS'(feat_now - e_last) < TIME_BITS'(cfg.cadence));

    falling  = (e_pbps != 30'd0) && (feat.bps5p5 <= {1'b0, e_pbps, 2'b00});
    growing  = feat.q_ge40 && ({1'b0, feat.queue} > ({1'b0, e_pq} + 17'd10));
    cend_use = (feat.urgent || falling || growing) ? feat_cend : e_cend;
    in_cong  = feat.urgent || (feat_now < cend_use);

    priority if (feat.mode == MODE_OFF) begin
      desired = 3'd0;
      reason  = RSN_OFF;
    end else if (in_cong) begin
      desired = feat.urgent ? 3'd0 : ((e_appl > 3'd1) ? 3'd1 : e_appl);
      reason  = RSN_CONGESTED;
    end else if (feat.mode == MODE_FIXED) begin
      desired = RATIO_MAX;
      reason  = RSN_FIXED;
    end else if (!feat.fresh || feat.insuff) begin
      desired = (e_appl > 3'd2) ? 3'd2 : e_appl;
      reason  = !feat.fresh ? RSN_STALE : RSN_INSUFF;
    end else begin
      desired = feat.band;
      reason  = (feat.band == 3'd0) ? RSN_HEALTHY : RSN_LOSS;
    end

    immediate = (feat.mode != MODE_ADAPT) || !feat.fresh || feat.insuff ||
                (reason == RSN_CONGESTED);

    // pending candidate, restarted when the target moves
    new_cand = !e_cv || (e_cr != desired);
    cs1      = new_cand ? feat_now : e_cs;
    cc1      = new_cand ? 2'd0 : e_cc;

    mode_nxt   = mode_r;
    seen_nxt   = seen_r;
    last_nxt   = last_r;
    pbps_nxt   = pbps_r;
    pq_nxt     = pq_r;
    cend_nxt   = cend_r;
    appl_nxt   = appl_r;
    cv_nxt     = cv_r;
    cr_nxt     = cr_r;
    cs_nxt     = cs_r;
    cc_nxt     = cc_r;
    sgen_nxt   = sgen_r;
    ver_nxt    = ver_r;
    hratio_nxt = hratio_r;
    hkfp_nxt   = hkfp_r;
    hrsn_nxt   = hrsn_r;

    // a gated word implies no clear, so the state simply holds
    if (take && !gate) begin
      mode_nxt = feat.mode;
      seen_nxt = 1'b1;
      last_nxt = feat_now;
      pbps_nxt = feat.bps;
      pq_nxt   = feat.queue;
      cend_nxt = cend_use;
      appl_nxt = e_appl;
      cv_nxt   = e_cv;
      cr_nxt   = e_cr;
      cs_nxt   = e_cs;
      cc_nxt   = e_cc;
      if (immediate) begin
        appl_nxt = desired;
        cv_nxt   = 1'b0;
        cc_nxt   = 2'd0;
      end else if (desired != e_appl) begin
        cv_nxt = 1'b1;
        cr_nxt = desired;
        cs_nxt = cs1;
        cc_nxt = ((feat_gen != e_sgen) && (cc1 != 2'd3)) ? cc1 + 2'd1 : cc1;
        // upgrades need two generations, downgrades also the hold time
        if (cc_nxt >= 2'd2 && ((desired > e_appl) ||
            (TIME_BITS'(feat_now - cs1) >= TIME_BITS'(cfg.down_hold)))) begin
          appl_nxt = desired;
          cv_nxt   = 1'b0;
        end
      end else begin
        cv_nxt = 1'b0;
        cc_nxt = 2'd0;
      end
      sgen_nxt   = feat_gen;
      ver_nxt    = ver_r + 32'd1;
      hratio_nxt = appl_nxt;
      hkfp_nxt   = feat.mode == MODE_ADAPT;
      hrsn_nxt   = reason;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      mode_r   <= MODE_OFF;
      seen_r   <= 1'b0;
      last_r   <= '0;
      pbps_r   <= '0;
      pq_r     <= '0;
      cend_r   <= '0;
      appl_r   <= 3'd0;
      cv_r     <= 1'b0;
      cr_r     <= '0;
      cs_r     <= '0;
      cc_r     <= '0;
      sgen_r   <= '0;
      ver_r    <= '0;
      hratio_r <= '0;
      hkfp_r   <= 1'b0;
      hrsn_r   <= RSN_STARTUP;
    end else begin
      if (feat_ready) begin
        out_v_r <= feat_valid;
      end
      mode_r   <= mode_nxt;
      seen_r   <= seen_nxt;
      last_r   <= last_nxt;
      pbps_r   <= pbps_nxt;
      pq_r     <= pq_nxt;
      cend_r   <= cend_nxt;
      appl_r   <= appl_nxt;
      cv_r     <= cv_nxt;
      cr_r     <= cr_nxt;
      cs_r     <= cs_nxt;
      cc_r     <= cc_nxt;
      sgen_r   <= sgen_nxt;
      ver_r    <= ver_nxt;
      hratio_r <= hratio_nxt;
      hkfp_r   <= hkfp_nxt;
      hrsn_r   <= hrsn_nxt;
    end
  end

  assign res_valid   = out_v_r;
  assign res_version = ver_r;
  assign res_ratio   = hratio_r;
  assign res_kfp     = hkfp_r;
  assign res_reason  = hrsn_r;

endmodule

>>> hw/rtl/fec_ratio_adaptation.sv
// Forward error correction ratio controller. One snapshot word in gives one
// decision word out, via the feature register, then the decision and state
// register. A new word is taken every cycle unless stalled: the controller
// state loop closes through the decision register, and it also holds the word
// on the output until it is taken. The output word carries the version, the
// applied ratio in 0.05 steps, the keyframe priority bit and the reason.
// Registers sit on the APB port at byte addresses 0x00 initial ratio,
// 0x04 cadence, 0x08 congestion hold, 0x0C minimum samples, 0x10 downgrade
// hold; write them only while no word is in flight. No clearing pass.
// depends on fra_pkg, fra_feature and fra_decide

module fec_ratio_adaptation #(
  parameter int TIME_BITS = fra_pkg::TIME_BITS_DEF,
  parameter int GEN_BITS  = fra_pkg::GEN_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fec_mode, now_ms, congested_flag, queue_delay, link_rate, rtt_ms,
  // feedback_time_ms, sample_count, lost_count, longest_loss_run, feedback_gen, pad
  input  logic [fra_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // config_version, ratio_steps, kf_prio, decision_reason, pad
  output logic [fra_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fra_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [fra_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [fra_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import fra_pkg::*;

  cfg_t                 cfg_r;
  in_item_t             item;
  logic                 feat_valid, feat_ready;
  feat_t                feat;
  logic [TIME_BITS-1:0] feat_now, feat_cend;
  logic [GEN_BITS-1:0]  feat_gen;
  logic [31:0]          res_version;
  logic [2:0]           res_ratio;
  logic                 res_kfp;
  reason_t              res_reason;

  assign cfg_pready = 1'b1;
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_ratio  <= 3'd0;
      cfg_r.cadence     <= 16'd200;
      cfg_r.cong_hold   <= 16'd1000;
      cfg_r.min_samples <= 16'd40;
      cfg_r.down_hold   <= 16'd3000;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        CFG_INIT_RATIO: cfg_r.init_ratio  <= cfg_pwdata[2:0];
        CFG_CADENCE:    cfg_r.cadence     <= cfg_pwdata[15:0];
        CFG_CONG_HOLD:  cfg_r.cong_hold   <= cfg_pwdata[15:0];
        CFG_MIN_SAMP:   cfg_r.min_samples <= cfg_pwdata[15:0];
        CFG_DOWN_HOLD:  cfg_r.down_hold   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      CFG_INIT_RATIO: cfg_prdata = 32'(cfg_r.init_ratio);
      CFG_CADENCE:    cfg_prdata = 32'(cfg_r.cadence);
      CFG_CONG_HOLD:  cfg_prdata = 32'(cfg_r.cong_hold);
      CFG_MIN_SAMP:   cfg_prdata = 32'(cfg_r.min_samples);
      CFG_DOWN_HOLD:  cfg_prdata = 32'(cfg_r.down_hold);
      default:        cfg_prdata = 32'd0;
    endcase
  end

  // word unpacking, lowest field first
  always_comb begin
    item.fec_mode         = in_tdata[1:0];
    item.now_ms           = in_tdata[41:2];
    item.congested_flag   = in_tdata[42];
    item.queue_delay      = in_tdata[58:43];
    item.link_rate        = in_tdata[88:59];
    item.rtt_ms           = in_tdata[104:89];
    item.feedback_time_ms = in_tdata[145:105];
    item.sample_count     = in_tdata[161:146];
    item.lost_count       = in_tdata[177:162];
    item.longest_loss_run = in_tdata[193:178];
    item.feedback_gen     = in_tdata[225:194];
  end

  fra_feature #(
    .TIME_BITS (TIME_BITS),
    .GEN_BITS  (GEN_BITS)
  ) u_feature (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .item       (item),
    .cfg        (cfg_r),
    .feat_valid (feat_valid),
    .feat_ready (feat_ready),
    .feat       (feat),
    .feat_now   (feat_now),
    .feat_cend  (feat_cend),
    .feat_gen   (feat_gen)
  );

  fra_decide #(
    .TIME_BITS (TIME_BITS),
    .GEN_BITS  (GEN_BITS)
  ) u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .feat_valid  (feat_valid),
    .feat_ready  (feat_ready),
    .feat        (feat),
    .feat_now    (feat_now),
    .feat_cend   (feat_cend),
    .feat_gen    (feat_gen),
    .cfg         (cfg_r),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_version (res_version),
    .res_ratio   (res_ratio),
    .res_kfp     (res_kfp),
    .res_reason  (res_reason)
  );

  assign out_tdata = {1'b0, res_reason, res_kfp, res_ratio, res_version};

endmodule
